// ===== sv/cds_pkg.sv =====
package cds_pkg;

    localparam logic [13:0] YEAR_MIN    = 14'd1;
    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [13:0] LEAP_CYCLE  = 14'd400;
    localparam logic [13:0] YMOD_LAST   = LEAP_CYCLE - 14'd1;
    localparam logic [13:0] CENTURY_1   = 14'd100;
    localparam logic [13:0] CENTURY_2   = 14'd200;
    localparam logic [13:0] CENTURY_3   = 14'd300;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_FEB   = 5'd28;
    localparam logic [4:0] DAYS_FEB_L = 5'd29;

    typedef struct packed {
        logic        operation;
        logic [13:0] in_year;
        logic [3:0]  in_month;
        logic [4:0]  in_day;
        logic [11:0] offset_days;
    } t_in_word;

    typedef struct packed {
        logic [13:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic        out_of_range;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_WALK,
        ST_FINISH
    } t_state;

    function automatic logic [4:0] month_days(input logic leap, input logic [3:0] month);
        logic [4:0] days;
        case (month) inside
            MONTH_FEB:                                  days = leap ? DAYS_FEB_L : DAYS_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: days = DAYS_SHORT;
            default:                                    days = DAYS_LONG;
        endcase
        return days;
    endfunction

endpackage

// ===== sv/cds_sub.sv =====
module cds_sub (
    input  logic [13:0] i_a,
    input  logic [13:0] i_b,
    output logic [13:0] o_diff,
    output logic        o_borrow
);

    logic [14:0] w_diff;

    assign w_diff   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_diff[13:0];
    assign o_borrow = w_diff[14];

endmodule

// ===== sv/cds_days.sv =====
module cds_days (
    input  logic [13:0] i_ymod,
    input  logic [3:0]  i_month,
    output logic [4:0]  o_days
);

    logic w_leap;

    assign w_leap = (i_ymod[1:0] == 2'b00) &&
                    (i_ymod != cds_pkg::CENTURY_1) &&
                    (i_ymod != cds_pkg::CENTURY_2) &&
                    (i_ymod != cds_pkg::CENTURY_3);

    assign o_days = cds_pkg::month_days(w_leap, i_month);

endmodule

// ===== sv/calendar_date_shift.sv =====
// Sequence: the year is reduced modulo 400 by repeated subtraction, the date is checked, the
// months are walked, and the result is registered; an invalid start date skips the month walk.
// The year reduction and the month walk share one subtractor.
// The input stalls until the result is registered, so a new word is taken only after the last is done.
// Reset: synchronous, active low; clears the sequencer and the output valid.
module calendar_date_shift #(
    parameter int MAX_OFFSET = 4095
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  cds_pkg::t_in_word     i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cds_pkg::t_out_word    o_out_word
);

    localparam logic [16:0] MAX_W = 17'(MAX_OFFSET);

    cds_pkg::t_state    r_state, n_state;
    cds_pkg::t_in_word  r_in, n_in;
    cds_pkg::t_out_word r_out, n_out;
    logic               r_out_valid, n_out_valid;
    logic [13:0]        r_y, n_y;
    logic [3:0]         r_m, n_m;
    logic [12:0]        r_d, n_d;
    logic [11:0]        r_n, n_n;
    logic [13:0]        r_ymod, n_ymod;
    logic               r_bad, n_bad;

    logic               w_accept;
    logic [11:0]        w_n_sat;
    logic [13:0]        w_a, w_b, w_diff;
    logic               w_borrow;
    logic [4:0]         w_days_cur, w_days_prev;
    logic [3:0]         w_m_prev;
    logic [13:0]        w_ymod_prev, w_ymod_next;
    logic               w_valid_date;
    logic               w_take;
    logic               w_year_edge;
    logic               w_out_free;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != cds_pkg::ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_n_sat    = ({5'b0, i_in_word.offset_days} > MAX_W) ? MAX_W[11:0]
                                                                : i_in_word.offset_days;

    assign w_m_prev    = (r_m == cds_pkg::MONTH_JAN) ? cds_pkg::MONTH_DEC : r_m - 4'd1;
    assign w_ymod_prev = (r_m != cds_pkg::MONTH_JAN) ? r_ymod :
                         (r_ymod == 14'd0) ? cds_pkg::YMOD_LAST : r_ymod - 14'd1;
    assign w_ymod_next = (r_ymod == cds_pkg::YMOD_LAST) ? 14'd0 : r_ymod + 14'd1;

    cds_days u_days_cur (
        .i_ymod  (r_ymod),
        .i_month (r_m),
        .o_days  (w_days_cur)
    );

    cds_days u_days_prev (
        .i_ymod  (w_ymod_prev),
        .i_month (w_m_prev),
        .o_days  (w_days_prev)
    );

    always_comb begin
        unique case (r_state)
            cds_pkg::ST_MOD: begin
                w_a = r_ymod;
                w_b = cds_pkg::LEAP_CYCLE;
            end
            cds_pkg::ST_WALK: begin
                if (r_in.operation == 1'b0) begin
                    w_a = {1'b0, r_d};
                    w_b = {9'b0, w_days_cur};
                end else begin
                    w_a = {2'b0, r_n};
                    w_b = {1'b0, r_d};
                end
            end
            default: begin
                w_a = 14'd0;
                w_b = 14'd0;
            end
        endcase
    end

    cds_sub u_sub (
        .i_a      (w_a),
        .i_b      (w_b),
        .o_diff   (w_diff),
        .o_borrow (w_borrow)
    );

    assign w_valid_date = (r_y >= cds_pkg::YEAR_MIN) && (r_y <= cds_pkg::YEAR_MAX) &&
                          (r_m >= cds_pkg::MONTH_JAN) && (r_m <= cds_pkg::MONTH_DEC) &&
                          (r_d != 13'd0) && (r_d <= {8'b0, w_days_cur});

    assign w_take = (r_in.operation == 1'b0) ? (!w_borrow && (w_diff != 14'd0)) : !w_borrow;

    assign w_year_edge = (r_in.operation == 1'b0)
        ? ((r_m == cds_pkg::MONTH_DEC) && (r_y == cds_pkg::YEAR_MAX))
        : ((r_m == cds_pkg::MONTH_JAN) && (r_y == cds_pkg::YEAR_MIN));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cds_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = cds_pkg::ST_MOD;
                end
            end
            cds_pkg::ST_MOD: begin
                if (w_borrow) begin
                    n_state = cds_pkg::ST_CHECK;
                end
            end
            cds_pkg::ST_CHECK: begin
                n_state = w_valid_date ? cds_pkg::ST_WALK : cds_pkg::ST_FINISH;
            end
            cds_pkg::ST_WALK: begin
                if (!w_take || w_year_edge) begin
                    n_state = cds_pkg::ST_FINISH;
                end
            end
            cds_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = cds_pkg::ST_IDLE;
                end
            end
            default: n_state = cds_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        n_y         = r_y;
        n_m         = r_m;
        n_d         = r_d;
        n_n         = r_n;
        n_ymod      = r_ymod;
        n_bad       = r_bad;
        unique case (r_state)
            cds_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_in   = i_in_word;
                    n_y    = i_in_word.in_year;
                    n_m    = i_in_word.in_month;
                    n_d    = {8'b0, i_in_word.in_day};
                    n_n    = w_n_sat;
                    n_ymod = i_in_word.in_year;
                    n_bad  = 1'b0;
                end
            end
            cds_pkg::ST_MOD: begin
                if (!w_borrow) begin
                    n_ymod = w_diff;
                end
            end
            cds_pkg::ST_CHECK: begin
                if (!w_valid_date) begin
                    n_bad = 1'b1;
                end else if (r_in.operation == 1'b0) begin
                    n_d = r_d + {1'b0, r_n};
                end
            end
            cds_pkg::ST_WALK: begin
                if (r_in.operation == 1'b0) begin
                    if (w_take) begin
                        n_d = w_diff[12:0];
                        if (r_m == cds_pkg::MONTH_DEC) begin
                            if (r_y == cds_pkg::YEAR_MAX) begin
                                n_bad = 1'b1;
                            end else begin
                                n_m    = cds_pkg::MONTH_JAN;
                                n_y    = r_y + 14'd1;
                                n_ymod = w_ymod_next;
                            end
                        end else begin
                            n_m = r_m + 4'd1;
                        end
                    end
                end else begin
                    if (w_take) begin
                        n_n = w_diff[11:0];
                        if (w_year_edge) begin
                            n_bad = 1'b1;
                        end else begin
                            n_m    = w_m_prev;
                            n_y    = (r_m == cds_pkg::MONTH_JAN) ? r_y - 14'd1 : r_y;
                            n_ymod = w_ymod_prev;
                            n_d    = {8'b0, w_days_prev};
                        end
                    end else begin
                        n_d = r_d - {1'b0, r_n};
                    end
                end
            end
            cds_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_bad) begin
                        n_out.out_year  = r_in.in_year;
                        n_out.out_month = r_in.in_month;
                        n_out.out_day   = r_in.in_day;
                    end else begin
                        n_out.out_year  = r_y;
                        n_out.out_month = r_m;
                        n_out.out_day   = r_d[4:0];
                    end
                    n_out.out_of_range = r_bad;
                end
            end
            default: begin
                n_bad = r_bad;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cds_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bad       <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_out  <= n_out;
        r_y    <= n_y;
        r_m    <= n_m;
        r_d    <= n_d;
        r_n    <= n_n;
        r_ymod <= n_ymod;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    a_good_result_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.out_of_range) |->
        (o_out_word.out_month >= cds_pkg::MONTH_JAN) &&
        (o_out_word.out_month <= cds_pkg::MONTH_DEC) && (o_out_word.out_day != 5'd0))
        else $error("in-range result carries an impossible date");

    a_ymod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cds_pkg::ST_WALK) |-> (r_ymod < cds_pkg::LEAP_CYCLE))
        else $error("year residue not reduced during the month walk");

    a_finish_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cds_pkg::ST_FINISH && !w_out_free) |=> (r_state == cds_pkg::ST_FINISH))
        else $error("result dropped while the output was stalled");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int   SHIFT_LIMIT   = 4095;
    localparam logic OP_ADD        = 1'b0;
    localparam logic OP_SUB        = 1'b1;
    localparam int   DIRECTED_ROWS = 24;
    localparam int   RANDOM_WORDS  = 1900;
    localparam int   HOLD_CYCLES   = 600;
    localparam int   DRAIN_CYCLES  = 200;
    localparam int   REPORT_LIMIT  = 10;

    typedef struct packed {
        logic        op;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [11:0] offset;
        logic        known;
        logic [13:0] exp_year;
        logic [3:0]  exp_month;
        logic [4:0]  exp_day;
        logic        exp_flag;
    } t_dir_row;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    cds_pkg::t_in_word   i_in_word   = '0;
    logic                i_out_stall = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    cds_pkg::t_out_word  o_out_word;

    cds_pkg::t_out_word  expected_dates[$];
    cds_pkg::t_out_word  want;
    int         errors        = 0;
    int         dates_checked = 0;
    int         dates_flagged = 0;
    int         words_sent    = 0;
    int         gap_pct       = 0;
    int         stall_pct     = 0;
    logic       hold_armed    = 1'b0;

    // Rows with known set carry a result that follows directly from the rules:
    // a zero offset, an invalid start date, or a walk off either end of the years.
    t_dir_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_ADD, 2024, 1, 15, 0, 1, 2024, 1, 15, 0},
        '{OP_SUB, 1, 1, 1, 0, 1, 1, 1, 1, 0},
        '{OP_ADD, 9999, 12, 31, 1, 1, 9999, 12, 31, 1},
        '{OP_SUB, 1, 1, 1, 1, 1, 1, 1, 1, 1},
        '{OP_ADD, 9999, 12, 31, 4095, 1, 9999, 12, 31, 1},
        '{OP_SUB, 1, 1, 1, 4095, 1, 1, 1, 1, 1},
        '{OP_ADD, 0, 6, 10, 5, 1, 0, 6, 10, 1},
        '{OP_ADD, 10000, 1, 1, 3, 1, 10000, 1, 1, 1},
        '{OP_SUB, 16383, 15, 31, 4095, 1, 16383, 15, 31, 1},
        '{OP_SUB, 2023, 0, 10, 7, 1, 2023, 0, 10, 1},
        '{OP_ADD, 2023, 13, 1, 7, 1, 2023, 13, 1, 1},
        '{OP_ADD, 2023, 3, 0, 1, 1, 2023, 3, 0, 1},
        '{OP_ADD, 2023, 4, 31, 1, 1, 2023, 4, 31, 1},
        '{OP_ADD, 2023, 2, 29, 1, 1, 2023, 2, 29, 1},
        '{OP_ADD, 1900, 2, 29, 1, 1, 1900, 2, 29, 1},
        '{OP_ADD, 2000, 2, 29, 1, 0, 0, 0, 0, 0},
        '{OP_SUB, 2024, 3, 15, 15, 0, 0, 0, 0, 0},
        '{OP_SUB, 2023, 3, 1, 1, 0, 0, 0, 0, 0},
        '{OP_ADD, 2023, 12, 31, 1, 0, 0, 0, 0, 0},
        '{OP_ADD, 2023, 1, 1, 4095, 0, 0, 0, 0, 0},
        '{OP_SUB, 9999, 12, 31, 4095, 0, 0, 0, 0, 0},
        '{OP_ADD, 9988, 11, 30, 4095, 0, 0, 0, 0, 0},
        '{OP_SUB, 12, 3, 1, 4095, 0, 0, 0, 0, 0},
        '{OP_ADD, 2100, 2, 28, 1, 0, 0, 0, 0, 0}
    };

    calendar_date_shift #(
        .MAX_OFFSET(SHIFT_LIMIT)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned month_length(input int unsigned year,
                                                 input int unsigned month);
        logic leap;
        leap = (year % 4 == 0) && ((year % 400 == 0) || (year % 100 != 0));
        case (month) inside
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic cds_pkg::t_out_word shift_date(input cds_pkg::t_in_word w);
        int unsigned        year;
        int unsigned        month;
        int unsigned        day;
        int unsigned        left;
        logic               bad;
        cds_pkg::t_out_word r;
        year  = 32'(w.in_year);
        month = 32'(w.in_month);
        day   = 32'(w.in_day);
        left  = 32'(w.offset_days);
        bad   = 1'b0;
        if (left > SHIFT_LIMIT)
            left = SHIFT_LIMIT;
        if (year < 1 || year > 9999 || month < 1 || month > 12 || day < 1 ||
            day > month_length(year, month)) begin
            bad = 1'b1;
        end else if (w.operation == OP_ADD) begin
            day += left;
            while (!bad && day > month_length(year, month)) begin
                day -= month_length(year, month);
                month++;
                if (month > 12) begin
                    month = 1;
                    year++;
                    if (year > 9999)
                        bad = 1'b1;
                end
            end
        end else begin
            while (!bad && left >= day) begin
                left -= day;
                month--;
                if (month == 0) begin
                    month = 12;
                    year--;
                    if (year < 1)
                        bad = 1'b1;
                end
                if (!bad)
                    day = month_length(year, month);
            end
            if (!bad)
                day -= left;
        end
        if (bad) begin
            r.out_year  = w.in_year;
            r.out_month = w.in_month;
            r.out_day   = w.in_day;
        end else begin
            r.out_year  = year[13:0];
            r.out_month = month[3:0];
            r.out_day   = day[4:0];
        end
        r.out_of_range = bad;
        return r;
    endfunction

    // Mostly valid dates, weighted toward both ends of the year range and
    // century years; the rest is raw noise over the full field widths.
    function automatic cds_pkg::t_in_word random_word();
        cds_pkg::t_in_word w;
        int unsigned       pick;
        pick = $urandom_range(99);
        w.operation = 1'($urandom_range(1));
        if (pick < 8) begin
            w.in_year     = 14'($urandom_range(16383));
            w.in_month    = 4'($urandom_range(15));
            w.in_day      = 5'($urandom_range(31));
            w.offset_days = 12'($urandom_range(4095));
        end else begin
            pick = $urandom_range(99);
            if (pick < 15)
                w.in_year = 14'($urandom_range(15, 1));
            else if (pick < 30)
                w.in_year = 14'($urandom_range(9999, 9985));
            else if (pick < 40)
                w.in_year = 14'(100 * $urandom_range(99, 1));
            else
                w.in_year = 14'($urandom_range(9999, 1));
            w.in_month = 4'($urandom_range(12, 1));
            w.in_day   = 5'($urandom_range(month_length(32'(w.in_year), 32'(w.in_month)), 1));
            pick = $urandom_range(99);
            if (pick < 10)
                w.offset_days = {7'b0, w.in_day};
            else if (pick < 25)
                w.offset_days = 12'($urandom_range(40));
            else
                w.offset_days = 12'($urandom_range(4095));
        end
        return w;
    endfunction

    task automatic offer_word(input cds_pkg::t_in_word w, input logic known,
                              input cds_pkg::t_out_word given);
        cds_pkg::t_out_word next_date;
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        next_date      = known ? given : shift_date(w);
        expected_dates = {expected_dates, next_date};
        words_sent++;
    endtask

    initial begin
        logic hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_armed && !hold_done) begin
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_dates.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("Unexpected word: year %0d month %0d day %0d flag %0d",
                             o_out_word.out_year, o_out_word.out_month,
                             o_out_word.out_day, o_out_word.out_of_range);
            end else begin
                want = expected_dates.pop_front();
                dates_checked++;
                if (o_out_word.out_of_range)
                    dates_flagged++;
                if (o_out_word.out_year !== want.out_year ||
                    o_out_word.out_month !== want.out_month ||
                    o_out_word.out_day !== want.out_day ||
                    o_out_word.out_of_range !== want.out_of_range) begin
                    errors++;
                    if (errors <= REPORT_LIMIT) begin
                        $display("Mismatch on date %0d: expected %0d-%0d-%0d flag %0d",
                                 dates_checked, want.out_year, want.out_month,
                                 want.out_day, want.out_of_range);
                        $display("    got %0d-%0d-%0d flag %0d",
                                 o_out_word.out_year, o_out_word.out_month,
                                 o_out_word.out_day, o_out_word.out_of_range);
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        cds_pkg::t_in_word  w;
        cds_pkg::t_out_word given;
        gap_pct   = 10;
        stall_pct <= 51;
        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            w.operation    = directed_rows[i].op;
            w.in_year      = directed_rows[i].year;
            w.in_month     = directed_rows[i].month;
            w.in_day       = directed_rows[i].day;
            w.offset_days  = directed_rows[i].offset;
            given.out_year     = directed_rows[i].exp_year;
            given.out_month    = directed_rows[i].exp_month;
            given.out_day      = directed_rows[i].exp_day;
            given.out_of_range = directed_rows[i].exp_flag;
            offer_word(w, directed_rows[i].known, given);
        end

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 3) begin
                gap_pct   = 51;
                stall_pct <= 10;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                gap_pct   = 0;
                stall_pct <= 0;
            end else if (i == 2 * RANDOM_WORDS / 3 + 20) begin
                hold_armed <= 1'b1;
            end
            offer_word(random_word(), 1'b0, given);
        end
        i_in_valid <= 1'b0;

        while (expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);

        $display("Shifted %0d words (%0d directed), %0d results checked, %0d flagged.",
                 words_sent, DIRECTED_ROWS, dates_checked, dates_flagged);
        $display("Ran three idle patterns and one %0d-cycle output hold; %0d failures.",
                 HOLD_CYCLES, errors);
        if (errors == 0 && expected_dates.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== calendar_date_shift.f =====
sv/cds_pkg.sv
sv/cds_sub.sv
sv/cds_days.sv
sv/calendar_date_shift.sv
tb/sv/tb_top.sv
